// ----- hdl/arpmru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpmru_pkg: shared types and constants of the ARP cache table
// Field widths, request operation codes, result status codes and the
// default table depth.
// ----------------------------------------------------------------------------
package arpmru_pkg;

    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int OCTET_W     = 8;
    localparam int ENTRIES_DEF = 16;

    // last octet that marks a broadcast address, never learned
    localparam logic [OCTET_W-1:0] LAST_OCTET_BCAST = 8'hFF;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_REFRESHED = 3'd2,
        ST_INSERTED  = 3'd3,
        ST_EVICTED   = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

endpackage
`default_nettype wire

// ----- hdl/arpmru_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpmru_req_if: request channel of the ARP cache table
// Valid/ready handshake carrying the operation, IPv4 address and MAC.
// ----------------------------------------------------------------------------
interface arpmru_req_if;
    import arpmru_pkg::*;

    logic                valid;
    logic                ready;
    op_t                 operation;
    logic [IP_W-1:0]     ip_addr;
    logic [MAC_W-1:0]    mac_addr;

    modport source (
        output valid,
        output operation,
        output ip_addr,
        output mac_addr,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  ip_addr,
        input  mac_addr,
        output ready
    );

endinterface
`default_nettype wire

// ----- hdl/arpmru_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpmru_rsp_if: response channel of the ARP cache table
// Valid/ready handshake carrying status, hit flag and returned MAC.
// ----------------------------------------------------------------------------
interface arpmru_rsp_if;
    import arpmru_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic                hit;
    logic [MAC_W-1:0]    mac_out;

    modport source (
        output valid,
        output status,
        output hit,
        output mac_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  hit,
        input  mac_out,
        output ready
    );

endinterface
`default_nettype wire

// ----- hdl/arp_cache_mru_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_mru_table_unit: IPv4-to-MAC cache kept in recency order
// Fully associative table of ENTRIES slots with a per-slot recency rank.
// Lookups return the MAC of a matching slot; updates refresh or insert,
// evicting the least recent slot when the table is full.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per handshake (operation, ip_addr, mac_addr).
//   rsp  : exactly one response per request, in request order.
//   Every request is captured in an input register; one pass of compare,
//   rank update and decode then writes the table and loads the response
//   register. One request is taken every cycle while the response side
//   does not stall. That pass (the parallel address compare over all
//   slots plus the rank compare) sets the clock.
//   A stalled response holds in its register; the input register keeps
//   one request waiting behind it, and req.ready drops only while both
//   are full and rsp.ready is low.
//   Reset clears all valid bits and ranks and empties both registers;
//   the table is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module arp_cache_mru_table_unit #(
    parameter int ENTRIES = arpmru_pkg::ENTRIES_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    arpmru_req_if.sink   req,
    arpmru_rsp_if.source rsp
);
    import arpmru_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);

    // table storage
    logic [ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]    ip_reg   [ENTRIES];
    logic [MAC_W-1:0]   mac_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_reg [ENTRIES];

    // input register
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [IP_W-1:0]    s1_ip_reg;
    logic [MAC_W-1:0]   s1_mac_reg;

    // response register
    logic               rsp_valid_reg;
    status_t            rsp_status_reg;
    logic               rsp_hit_reg;
    logic [MAC_W-1:0]   rsp_mac_reg;

    logic               out_free;
    logic               s1_fire;

    // table decode
    logic [ENTRIES-1:0] match;
    logic               hit_any;
    logic [RANK_W-1:0]  hit_rank;
    logic [MAC_W-1:0]   hit_mac;
    logic               full;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] evict_oh;
    logic               ignored;

    // decided action
    logic               do_touch;
    logic [ENTRIES-1:0] touch_oh;
    logic [RANK_W:0]    touch_rank;
    logic               do_mac_wr;
    logic               do_insert;
    status_t            status_next;
    logic               hit_next;
    logic [MAC_W-1:0]   mac_out_next;

    // handshake: advance when the response register can take a result
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;

    // capture request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg  <= req.operation;
            s1_ip_reg  <= req.ip_addr;
            s1_mac_reg <= req.mac_addr;
        end
    end

    // compare address against every slot, gather matched rank and MAC
    always_comb
    begin
        hit_rank = '0;
        hit_mac  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]    = valid_reg[i] && (ip_reg[i] == s1_ip_reg);
            evict_oh[i] = (rank_reg[i] == RANK_W'(ENTRIES - 1));
            if (match[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
                hit_mac  = hit_mac | mac_reg[i];
            end
        end
    end

    assign hit_any = |match;
    assign full    = &valid_reg;
    // lowest clear valid bit
    assign free_oh = ~valid_reg & (valid_reg + ENTRIES'(1));
    assign ignored = (s1_ip_reg == '0) ||
                     (s1_ip_reg[OCTET_W-1:0] == LAST_OCTET_BCAST);

    // decide result and table action
    always_comb
    begin
        do_touch     = 1'b0;
        touch_oh     = '0;
        touch_rank   = '0;
        do_mac_wr    = 1'b0;
        do_insert    = 1'b0;
        status_next  = ST_MISS;
        hit_next     = 1'b0;
        mac_out_next = '0;
        if (s1_op_reg == OP_LOOKUP)
        begin
            if (hit_any)
            begin
                do_touch     = 1'b1;
                touch_oh     = match;
                touch_rank   = {1'b0, hit_rank};
                status_next  = ST_HIT;
                hit_next     = 1'b1;
                mac_out_next = hit_mac;
            end
        end
        else if (ignored)
        begin
            status_next = ST_IGNORED;
        end
        else if (hit_any)
        begin
            do_touch    = 1'b1;
            do_mac_wr   = 1'b1;
            touch_oh    = match;
            touch_rank  = {1'b0, hit_rank};
            status_next = ST_REFRESHED;
            hit_next    = 1'b1;
        end
        else
        begin
            do_touch  = 1'b1;
            do_mac_wr = 1'b1;
            do_insert = 1'b1;
            if (full)
            begin
                // least recent slot holds the top rank
                touch_oh    = evict_oh;
                touch_rank  = (RANK_W+1)'(ENTRIES - 1);
                status_next = ST_EVICTED;
            end
            else
            begin
                // new slot counts as older than all others
                touch_oh    = free_oh;
                touch_rank  = (RANK_W+1)'(ENTRIES);
                status_next = ST_INSERTED;
            end
        end
    end

    // update valid bits and recency ranks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (s1_fire && do_touch)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (touch_oh[i])
                begin
                    rank_reg[i] <= '0;
                    if (do_insert)
                    begin
                        valid_reg[i] <= 1'b1;
                    end
                end
                else if (valid_reg[i] && ({1'b0, rank_reg[i]} < touch_rank))
                begin
                    rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    // write address and MAC payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (touch_oh[i] && do_mac_wr)
                begin
                    mac_reg[i] <= s1_mac_reg;
                end
                if (touch_oh[i] && do_insert)
                begin
                    ip_reg[i] <= s1_ip_reg;
                end
            end
        end
    end

    // hold response until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            rsp_status_reg <= status_next;
            rsp_hit_reg    <= hit_next;
            rsp_mac_reg    <= mac_out_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.hit     = rsp_hit_reg;
    assign rsp.mac_out = rsp_mac_reg;

    // an address lives in at most one slot
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(match))
        else $error("address matched more than one slot");

    // a full table has exactly one least recent slot
    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && do_insert && full) |-> $onehot(evict_oh))
        else $error("eviction victim not unique");

    // slots are never freed
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) >= $countones($past(valid_reg))))
        else $error("valid slot count dropped");

    // hit flag only on a lookup hit or a refresh
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_hit_reg) |->
        (rsp_status_reg == ST_HIT || rsp_status_reg == ST_REFRESHED))
        else $error("hit flag with wrong status");

    // returned MAC is zero unless a lookup hit
    a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg != ST_HIT) |-> (rsp_mac_reg == '0))
        else $error("nonzero MAC on non-hit response");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ARP cache recency table
// Drives lookup and learn requests through the request channel and checks
// every response against a local model of the table or the reply typed
// into a directed row. A short table of directed requests comes first,
// then random traffic over a small working set of addresses, whose size
// alternates below and above the table depth: hits, refreshes, evictions.
// ----------------------------------------------------------------------------
module testbench;
    import arpmru_pkg::*;

    localparam int TB_ENTRIES  = ENTRIES_DEF;
    localparam int PROBE_ROWS  = 14;
    localparam int RANDOM_REQS = 1340;
    localparam int POOL_SIZE   = 24;

    typedef struct {
        status_t          status;
        logic             hit;
        logic [MAC_W-1:0] mac_out;
    } arp_reply_t;

    typedef struct {
        op_t              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        bit               fixed;
        arp_reply_t       reply;
    } arp_probe_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   mismatches;

    // expectation typed into the directed table, travels with the request
    bit         row_fixed;
    arp_reply_t row_reply;

    // local copy of the cache table
    bit               cache_valid [TB_ENTRIES];
    logic [IP_W-1:0]  cache_ip    [TB_ENTRIES];
    logic [MAC_W-1:0] cache_mac   [TB_ENTRIES];
    int               cache_rank  [TB_ENTRIES];

    arp_reply_t pending_replies[$];
    arp_probe_t probe_rows[PROBE_ROWS];
    logic [IP_W-1:0] addr_pool[POOL_SIZE];

    arpmru_req_if req_ch();
    arpmru_rsp_if rsp_ch();

    arp_cache_mru_table_unit #(
        .ENTRIES (TB_ENTRIES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // make slot s the most recent, age every slot that was ahead of it
    function automatic void promote_slot(input int s);
        int r;
        r = cache_rank[s];
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            if (cache_valid[i] && i != s && cache_rank[i] < r)
                cache_rank[i]++;
        end
        cache_rank[s] = 0;
    endfunction

    // apply one request to the local table and return the reply it causes
    function automatic arp_reply_t resolve_arp(input op_t op, input logic [IP_W-1:0] ip,
                                               input logic [MAC_W-1:0] mac);
        arp_reply_t rep;
        int s;
        int victim;
        s = -1;
        victim = -1;
        rep.status  = ST_MISS;
        rep.hit     = 1'b0;
        rep.mac_out = '0;
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            if (s < 0 && cache_valid[i] && cache_ip[i] == ip)
                s = i;
        end
        if (op == OP_LOOKUP)
        begin
            if (s >= 0)
            begin
                promote_slot(s);
                rep.status  = ST_HIT;
                rep.hit     = 1'b1;
                rep.mac_out = cache_mac[s];
            end
        end
        else if (ip == '0 || ip[OCTET_W-1:0] == LAST_OCTET_BCAST)
        begin
            rep.status = ST_IGNORED;
        end
        else if (s >= 0)
        begin
            cache_mac[s] = mac;
            promote_slot(s);
            rep.status = ST_REFRESHED;
            rep.hit    = 1'b1;
        end
        else
        begin
            rep.status = ST_INSERTED;
            for (int i = 0; i < TB_ENTRIES; i++)
            begin
                if (victim < 0 && !cache_valid[i])
                    victim = i;
            end
            if (victim < 0)
            begin
                // full table: replace the least recent slot
                victim = 0;
                for (int i = 1; i < TB_ENTRIES; i++)
                begin
                    if (cache_rank[i] > cache_rank[victim])
                        victim = i;
                end
                rep.status = ST_EVICTED;
            end
            else
            begin
                // a fresh slot starts behind everything so that all others age
                cache_rank[victim] = TB_ENTRIES;
            end
            cache_valid[victim] = 1'b1;
            cache_ip[victim]    = ip;
            cache_mac[victim]   = mac;
            promote_slot(victim);
        end
        return rep;
    endfunction

    // hold the request until it is taken, with random idle cycles ahead of it outside the calm stretch
    task automatic send_request(input op_t op, input logic [IP_W-1:0] ip,
                                input logic [MAC_W-1:0] mac, input bit fixed,
                                input arp_reply_t reply);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.ip_addr   <= ip;
        req_ch.mac_addr  <= mac;
        row_fixed        <= fixed;
        row_reply        <= reply;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // stall the response side at random, except in the calm stretch
    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin
        arp_reply_t predicted;
        arp_reply_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = resolve_arp(req_ch.operation, req_ch.ip_addr,
                                        req_ch.mac_addr);
                pending_replies.push_back(row_fixed ? row_reply : predicted);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with nothing pending: status %0d",
                                 $realtime, rsp_ch.status);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.hit !== want.hit ||
                        rsp_ch.mac_out !== want.mac_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected status %0d hit %0b mac %h, got %0d %0b %h",
                                     $realtime, want.status, want.hit, want.mac_out,
                                     rsp_ch.status, rsp_ch.hit, rsp_ch.mac_out);
                    end
                end
            end
        end
    end

    initial
    begin
        arp_reply_t       no_reply;
        op_t              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        int               pick;
        int               span;

        no_reply = '{ST_HIT, 1'b0, '0};
        rst_n            = 1'b0;
        calm             = 1'b0;
        mismatches       = 0;
        row_fixed        = 1'b0;
        row_reply        = no_reply;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_LOOKUP;
        req_ch.ip_addr   = '0;
        req_ch.mac_addr  = '0;
        rsp_ch.ready     = 1'b0;
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_ip[i]    = '0;
            cache_mac[i]   = '0;
            cache_rank[i]  = 0;
        end

        // directed requests: empty table, ignored addresses, insert, hit, refresh
        probe_rows[0]  = '{OP_LOOKUP, 32'h0A00_0001, 48'h0, 1'b1, '{ST_MISS, 1'b0, 48'h0}};
        probe_rows[1]  = '{OP_UPDATE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1,
                           '{ST_IGNORED, 1'b0, 48'h0}};
        probe_rows[2]  = '{OP_UPDATE, 32'h0A00_00FF, 48'h1234_5678_9ABC, 1'b1,
                           '{ST_IGNORED, 1'b0, 48'h0}};
        probe_rows[3]  = '{OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
                           '{ST_IGNORED, 1'b0, 48'h0}};
        probe_rows[4]  = '{OP_LOOKUP, 32'h0000_0000, 48'h0, 1'b1, '{ST_MISS, 1'b0, 48'h0}};
        probe_rows[5]  = '{OP_UPDATE, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 1'b1,
                           '{ST_INSERTED, 1'b0, 48'h0}};
        probe_rows[6]  = '{OP_LOOKUP, 32'h0A00_0001, 48'h0, 1'b1,
                           '{ST_HIT, 1'b1, 48'hFFFF_FFFF_FFFF}};
        probe_rows[7]  = '{OP_UPDATE, 32'h0A00_0001, 48'h0, 1'b1,
                           '{ST_REFRESHED, 1'b1, 48'h0}};
        probe_rows[8]  = '{OP_LOOKUP, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 1'b1,
                           '{ST_HIT, 1'b1, 48'h0}};
        probe_rows[9]  = '{OP_UPDATE, 32'hFFFF_FFFE, 48'h0123_4567_89AB, 1'b0, no_reply};
        probe_rows[10] = '{OP_UPDATE, 32'h0000_0001, 48'hFEDC_BA98_7654, 1'b0, no_reply};
        probe_rows[11] = '{OP_LOOKUP, 32'h0000_00FF, 48'h0, 1'b1, '{ST_MISS, 1'b0, 48'h0}};
        probe_rows[12] = '{OP_LOOKUP, 32'hFFFF_FFFE, 48'h0, 1'b0, no_reply};
        probe_rows[13] = '{OP_LOOKUP, 32'h0000_0001, 48'h0, 1'b0, no_reply};

        // working set of learnable addresses
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            ip = $urandom();
            while (ip == '0 || ip[OCTET_W-1:0] == LAST_OCTET_BCAST)
                ip = $urandom();
            addr_pool[i] = ip;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < PROBE_ROWS; n++)
            send_request(probe_rows[n].op, probe_rows[n].ip, probe_rows[n].mac,
                         probe_rows[n].fixed, probe_rows[n].reply);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            calm = (n >= 500 && n < 800);
            // small set mostly hits, large set keeps the table evicting
            span = ((n / 150) % 2 == 0) ? 12 : POOL_SIZE;
            op   = op_t'($urandom_range(0, 1));
            mac  = {16'($urandom()), 32'($urandom())};
            pick = $urandom_range(0, 99);
            if (pick < 80)
                ip = addr_pool[$urandom_range(0, span - 1)];
            else if (pick < 88)
                ip = $urandom();
            else if (pick < 94)
                ip = ($urandom_range(0, 1) == 0) ? '0 :
                     {24'($urandom()), LAST_OCTET_BCAST};
            else
                ip = addr_pool[$urandom_range(0, span - 1)] ^
                     (32'h1 << $urandom_range(0, IP_W - 1));
            send_request(op, ip, mac, 1'b0, no_reply);
        end
        req_ch.valid <= 1'b0;
        // let the last accepted request reach the pending queue
        @(posedge clk);

        // drain, then let the pipeline settle
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/arpmru_pkg.sv
hdl/arpmru_req_if.sv
hdl/arpmru_rsp_if.sv
hdl/arp_cache_mru_table_unit.sv
tb/testbench.sv
